FILE: rtl/csod_pkg.sv
package csod_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int FRAC_W           = 4;
    localparam int MAX_CALIBRATION  = 1023;
    localparam int WINDOW_DEPTH_DEF = 7;

    localparam int CFG_COUNT_W = 10;
    localparam int CFG_K_W     = 4;
    localparam int HITS_W      = 4;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    localparam int CNT_W       = $clog2(MAX_CALIBRATION + 1);
    localparam int TOT_W       = SAMPLE_W + CNT_W;
    localparam int SQ_W        = 2 * SAMPLE_W + CNT_W;
    localparam int DIFF_W      = 2 * TOT_W;
    localparam int DIVN_W      = DIFF_W + 2 * FRAC_W;
    localparam int DVSR_W      = 2 * CNT_W;
    localparam int AVG_DIVN_W  = TOT_W + FRAC_W;
    localparam int VAR_W       = 2 * SAMPLE_W + 2 * FRAC_W;
    localparam int ROOT_W      = VAR_W / 2;
    localparam int AVG_W       = 20;
    localparam int LIMIT_W     = 24;
    localparam int STEP_W      = $clog2(DIVN_W + 1);
    localparam int LOOP_W      = $clog2(TOT_W + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_MULT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HITS_LONG   = 2'd2;

    localparam logic [2:0] ACT_CALIB = 3'd0;
    localparam logic [2:0] ACT_DRIVE = 3'd1;
    localparam logic [2:0] ACT_BUMP  = 3'd2;
    localparam logic [2:0] ACT_SHORT = 3'd3;
    localparam logic [2:0] ACT_LONG  = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sonar_sample;
        logic [SAMPLE_W-1:0] ir_sample;
        logic                bump_left;
        logic                bump_right;
    } sample_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [AVG_W-1:0]  sonar_average;
        logic [AVG_W-1:0]  ir_average;
        logic [HITS_W-1:0] hits_so_far;
    } result_t;

endpackage

FILE: rtl/csod_divider.sv
module csod_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [csod_pkg::STEP_W-1:0]   steps,
    input  logic [csod_pkg::DIVN_W-1:0]   dividend,
    input  logic [csod_pkg::DVSR_W-1:0]   divisor,
    output logic                          busy,
    output logic [csod_pkg::DIVN_W-1:0]   quotient
);
    import csod_pkg::*;

    logic [DIVN_W-1:0] work_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] divisor_reg;
    logic [STEP_W-1:0] count_reg;
    logic              busy_reg;
    logic [DVSR_W:0]   trial;
    logic              fits;

    // one quotient bit per cycle; dividend arrives aligned to the top
    assign trial = {rem_reg, work_reg[DIVN_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
        end
        else if (start)
        begin
            work_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            count_reg   <= steps;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            work_reg  <= {work_reg[DIVN_W-2:0], fits};
            rem_reg   <= fits ? DVSR_W'(trial - {1'b0, divisor_reg}) : trial[DVSR_W-1:0];
            count_reg <= count_reg - STEP_W'(1);
            if (count_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

FILE: rtl/calibrated_sigma_obstacle_detector.sv
// Obstacle detector with k-sigma thresholds learned from a calibration run.
// Input channel: sample_valid / sample_stall carry one beat of sonar, IR and
// bumper bits. A beat is taken when sample_valid is high and sample_stall low.
// Output channel: result_valid / result_stall carry exactly one result beat
// per input beat, in order. The result sits in an output register, so the
// input side is free again as soon as the result is loaded there.
// A normal beat runs through the bit-serial dividers that form both averages
// (30 quotient bits, one per cycle). The last calibration beat also runs a
// serial multiply for n*sum(x^2) and sum(x)^2, a 60-step division by n^2 and
// a 20-step square root, for both sensors in parallel.
// One beat is in work at a time; sample_stall stays high until its result
// is in the output register. A stalled result holds the output register and
// the next result waits inside the block.
// Reset clears counters, sums, thresholds and the window fill state (the window
// storage itself is not reset); configuration returns to calibration_count 100,
// sigma_multiplier 3, hits_before_long 3. Write configuration through cfg_write / cfg_index / cfg_data while idle.
module calibrated_sigma_obstacle_detector #(
    parameter int WINDOW_DEPTH = csod_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  csod_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output csod_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [csod_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [csod_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import csod_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WTOT_W = SAMPLE_W + FILL_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_AVG, ST_AVG_WAIT, ST_MUL_N, ST_MUL_T,
        ST_VAR, ST_VAR_WAIT, ST_SQRT, ST_LIMIT, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_COUNT_W-1:0] calib_count_reg;
    logic [CFG_K_W-1:0]     sigma_k_reg;
    logic [HITS_W-1:0]      hits_long_reg;

    // calibration statistics
    logic                   calibrated_reg;
    logic [CNT_W-1:0]       calib_seen_reg;
    logic [TOT_W-1:0]       sonar_total_reg, ir_total_reg;
    logic [SQ_W-1:0]        sonar_sq_reg, ir_sq_reg;
    logic [LIMIT_W-1:0]     sonar_low_reg, ir_high_reg;

    // moving window
    logic [SAMPLE_W-1:0]    sonar_win [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]    ir_win [WINDOW_DEPTH];
    logic [FILL_W-1:0]      fill_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [WTOT_W-1:0]      sonar_wtot_reg, ir_wtot_reg;
    logic [HITS_W-1:0]      hit_reg;

    // per-beat working registers
    logic                   bump_reg;
    logic [2:0]             action_reg;
    logic [AVG_W-1:0]       sonar_avg_reg, ir_avg_reg;

    // serial multiply and square root
    logic [DIFF_W-1:0]      sonar_acc_reg, ir_acc_reg;
    logic [DIFF_W-1:0]      sonar_add_reg, ir_add_reg;
    logic [TOT_W-1:0]       sonar_mul_reg, ir_mul_reg;
    logic [LOOP_W-1:0]      loop_reg;
    logic [VAR_W-1:0]       sonar_rem_reg, ir_rem_reg;
    logic [VAR_W-1:0]       sonar_root_reg, ir_root_reg;
    logic [VAR_W-1:0]       bit_reg;

    logic                   result_valid_reg;
    result_t                result_reg;

    logic                   accept;
    logic                   div_start;
    logic [STEP_W-1:0]      div_steps;
    logic [DIVN_W-1:0]      sonar_dividend, ir_dividend;
    logic [DVSR_W-1:0]      divisor;
    logic                   sonar_busy, ir_busy;
    logic [DIVN_W-1:0]      sonar_quot, ir_quot;
    logic [AVG_DIVN_W-1:0]  sonar_num, ir_num;
    logic [CNT_W-1:0]       n_eff;
    logic [2*SAMPLE_W-1:0]  sonar_square, ir_square;
    logic [WTOT_W-1:0]      sonar_wtot_next, ir_wtot_next;
    logic [AVG_W-1:0]       sonar_q, ir_q;
    logic                   detect;
    logic [HITS_W:0]        hit_inc;
    logic [VAR_W-1:0]       sonar_trial, ir_trial;
    logic [LIMIT_W-1:0]     sonar_ks, ir_ks;
    logic [LIMIT_W:0]       ir_high_sum;
    logic                   out_free;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign out_free     = !result_valid_reg || !result_stall;

    // effective calibration length: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (calib_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(calib_count_reg) > 32'(MAX_CALIBRATION))
        begin
            n_eff = CNT_W'(MAX_CALIBRATION);
        end
        else
        begin
            n_eff = CNT_W'(calib_count_reg);
        end
    end

    assign sonar_square = (2*SAMPLE_W)'(sample.sonar_sample) * (2*SAMPLE_W)'(sample.sonar_sample);
    assign ir_square    = (2*SAMPLE_W)'(sample.ir_sample) * (2*SAMPLE_W)'(sample.ir_sample);

    // window sums after this beat: grow while filling, else drop the oldest
    always_comb
    begin
        if (fill_reg < FILL_W'(WINDOW_DEPTH))
        begin
            sonar_wtot_next = sonar_wtot_reg + WTOT_W'(sample.sonar_sample);
            ir_wtot_next    = ir_wtot_reg + WTOT_W'(sample.ir_sample);
        end
        else
        begin
            sonar_wtot_next = sonar_wtot_reg - WTOT_W'(sonar_win[slot_reg])
                              + WTOT_W'(sample.sonar_sample);
            ir_wtot_next    = ir_wtot_reg - WTOT_W'(ir_win[slot_reg])
                              + WTOT_W'(sample.ir_sample);
        end
    end

    // divider operands: averages in ST_AVG, variance in ST_VAR
    assign sonar_num = calibrated_reg ? AVG_DIVN_W'({sonar_wtot_reg, {FRAC_W{1'b0}}})
                                      : {sonar_total_reg, {FRAC_W{1'b0}}};
    assign ir_num    = calibrated_reg ? AVG_DIVN_W'({ir_wtot_reg, {FRAC_W{1'b0}}})
                                      : {ir_total_reg, {FRAC_W{1'b0}}};

    always_comb
    begin
        div_start      = 1'b0;
        div_steps      = STEP_W'(AVG_DIVN_W);
        sonar_dividend = {sonar_num, {(DIVN_W-AVG_DIVN_W){1'b0}}};
        ir_dividend    = {ir_num, {(DIVN_W-AVG_DIVN_W){1'b0}}};
        divisor        = calibrated_reg ? DVSR_W'(fill_reg) : DVSR_W'(calib_seen_reg);
        case (state_reg)
            ST_AVG:
            begin
                div_start = 1'b1;
            end
            ST_VAR:
            begin
                div_start      = 1'b1;
                div_steps      = STEP_W'(DIVN_W);
                sonar_dividend = {sonar_acc_reg, {(2*FRAC_W){1'b0}}};
                ir_dividend    = {ir_acc_reg, {(2*FRAC_W){1'b0}}};
                divisor        = DVSR_W'(calib_seen_reg) * DVSR_W'(calib_seen_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    csod_divider u_sonar_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (sonar_dividend),
        .divisor  (divisor),
        .busy     (sonar_busy),
        .quotient (sonar_quot)
    );

    csod_divider u_ir_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (ir_dividend),
        .divisor  (divisor),
        .busy     (ir_busy),
        .quotient (ir_quot)
    );

    // obstacle: sonar closer than its limit and IR brighter than its limit
    assign sonar_q = sonar_quot[AVG_W-1:0];
    assign ir_q    = ir_quot[AVG_W-1:0];
    assign detect  = (LIMIT_W'(sonar_q) < sonar_low_reg) && (LIMIT_W'(ir_q) > ir_high_reg);
    assign hit_inc = {1'b0, hit_reg} + (HITS_W+1)'(1);

    assign sonar_trial = sonar_root_reg + bit_reg;
    assign ir_trial    = ir_root_reg + bit_reg;

    assign sonar_ks    = LIMIT_W'(sigma_k_reg) * LIMIT_W'(sonar_root_reg[ROOT_W-1:0]);
    assign ir_ks       = LIMIT_W'(sigma_k_reg) * LIMIT_W'(ir_root_reg[ROOT_W-1:0]);
    assign ir_high_sum = (LIMIT_W+1)'(ir_avg_reg) + (LIMIT_W+1)'(ir_ks);

    // window storage: write the newest sample over the oldest slot
    always_ff @(posedge clk)
    begin
        if (accept && calibrated_reg)
        begin
            sonar_win[slot_reg] <= sample.sonar_sample;
            ir_win[slot_reg]    <= sample.ir_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            calib_count_reg  <= CFG_COUNT_W'(100);
            sigma_k_reg      <= CFG_K_W'(3);
            hits_long_reg    <= HITS_W'(3);
            calibrated_reg   <= 1'b0;
            calib_seen_reg   <= '0;
            sonar_total_reg  <= '0;
            ir_total_reg     <= '0;
            sonar_sq_reg     <= '0;
            ir_sq_reg        <= '0;
            sonar_low_reg    <= '0;
            ir_high_reg      <= '0;
            fill_reg         <= '0;
            slot_reg         <= '0;
            sonar_wtot_reg   <= '0;
            ir_wtot_reg      <= '0;
            hit_reg          <= '0;
            bump_reg         <= 1'b0;
            action_reg       <= ACT_CALIB;
            sonar_avg_reg    <= '0;
            ir_avg_reg       <= '0;
            sonar_acc_reg    <= '0;
            ir_acc_reg       <= '0;
            sonar_add_reg    <= '0;
            ir_add_reg       <= '0;
            sonar_mul_reg    <= '0;
            ir_mul_reg       <= '0;
            loop_reg         <= '0;
            sonar_rem_reg    <= '0;
            ir_rem_reg       <= '0;
            sonar_root_reg   <= '0;
            ir_root_reg      <= '0;
            bit_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CALIB_COUNT: calib_count_reg <= cfg_data[CFG_COUNT_W-1:0];
                    REG_SIGMA_MULT:  sigma_k_reg     <= cfg_data[CFG_K_W-1:0];
                    REG_HITS_LONG:   hits_long_reg   <= cfg_data[HITS_W-1:0];
                    default:         hits_long_reg   <= hits_long_reg;
                endcase
            end

            // drop the output beat once taken, unless a new one loads now
            if (result_valid_reg && !result_stall && (state_reg != ST_EMIT))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        bump_reg <= sample.bump_left | sample.bump_right;
                        if (!calibrated_reg)
                        begin
                            calib_seen_reg  <= calib_seen_reg + CNT_W'(1);
                            sonar_total_reg <= sonar_total_reg + TOT_W'(sample.sonar_sample);
                            ir_total_reg    <= ir_total_reg + TOT_W'(sample.ir_sample);
                            sonar_sq_reg    <= sonar_sq_reg + SQ_W'(sonar_square);
                            ir_sq_reg       <= ir_sq_reg + SQ_W'(ir_square);
                        end
                        else
                        begin
                            if (fill_reg < FILL_W'(WINDOW_DEPTH))
                            begin
                                fill_reg <= fill_reg + FILL_W'(1);
                            end
                            sonar_wtot_reg <= sonar_wtot_next;
                            ir_wtot_reg    <= ir_wtot_next;
                            slot_reg <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                                        ? '0 : slot_reg + SLOT_W'(1);
                        end
                        state_reg <= ST_AVG;
                    end
                end

                ST_AVG:
                begin
                    state_reg <= ST_AVG_WAIT;
                end

                ST_AVG_WAIT:
                begin
                    if (!sonar_busy && !ir_busy)
                    begin
                        sonar_avg_reg <= sonar_q;
                        ir_avg_reg    <= ir_q;
                        if (!calibrated_reg)
                        begin
                            action_reg <= ACT_CALIB;
                            if (calib_seen_reg >= n_eff)
                            begin
                                // start n * sum(x^2)
                                sonar_acc_reg <= '0;
                                ir_acc_reg    <= '0;
                                sonar_add_reg <= DIFF_W'(sonar_sq_reg);
                                ir_add_reg    <= DIFF_W'(ir_sq_reg);
                                sonar_mul_reg <= TOT_W'(calib_seen_reg);
                                ir_mul_reg    <= TOT_W'(calib_seen_reg);
                                loop_reg      <= LOOP_W'(CNT_W);
                                state_reg     <= ST_MUL_N;
                            end
                            else
                            begin
                                state_reg <= ST_EMIT;
                            end
                        end
                        else
                        begin
                            if (bump_reg)
                            begin
                                action_reg <= ACT_BUMP;
                            end
                            else if (detect)
                            begin
                                if (hit_inc > {1'b0, hits_long_reg})
                                begin
                                    action_reg <= ACT_LONG;
                                    hit_reg    <= '0;
                                end
                                else
                                begin
                                    action_reg <= ACT_SHORT;
                                    hit_reg    <= hit_inc[HITS_W-1:0];
                                end
                                fill_reg       <= '0;
                                slot_reg       <= '0;
                                sonar_wtot_reg <= '0;
                                ir_wtot_reg    <= '0;
                            end
                            else
                            begin
                                action_reg <= ACT_DRIVE;
                            end
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                ST_MUL_N:
                begin
                    if (sonar_mul_reg[0])
                    begin
                        sonar_acc_reg <= sonar_acc_reg + sonar_add_reg;
                    end
                    if (ir_mul_reg[0])
                    begin
                        ir_acc_reg <= ir_acc_reg + ir_add_reg;
                    end
                    sonar_mul_reg <= sonar_mul_reg >> 1;
                    ir_mul_reg    <= ir_mul_reg >> 1;
                    sonar_add_reg <= sonar_add_reg << 1;
                    ir_add_reg    <= ir_add_reg << 1;
                    loop_reg      <= loop_reg - LOOP_W'(1);
                    if (loop_reg == LOOP_W'(1))
                    begin
                        // then subtract sum(x)^2
                        sonar_mul_reg <= sonar_total_reg;
                        ir_mul_reg    <= ir_total_reg;
                        sonar_add_reg <= DIFF_W'(sonar_total_reg);
                        ir_add_reg    <= DIFF_W'(ir_total_reg);
                        loop_reg      <= LOOP_W'(TOT_W);
                        state_reg     <= ST_MUL_T;
                    end
                end

                ST_MUL_T:
                begin
                    if (sonar_mul_reg[0])
                    begin
                        sonar_acc_reg <= sonar_acc_reg - sonar_add_reg;
                    end
                    if (ir_mul_reg[0])
                    begin
                        ir_acc_reg <= ir_acc_reg - ir_add_reg;
                    end
                    sonar_mul_reg <= sonar_mul_reg >> 1;
                    ir_mul_reg    <= ir_mul_reg >> 1;
                    sonar_add_reg <= sonar_add_reg << 1;
                    ir_add_reg    <= ir_add_reg << 1;
                    loop_reg      <= loop_reg - LOOP_W'(1);
                    if (loop_reg == LOOP_W'(1))
                    begin
                        state_reg <= ST_VAR;
                    end
                end

                ST_VAR:
                begin
                    state_reg <= ST_VAR_WAIT;
                end

                ST_VAR_WAIT:
                begin
                    if (!sonar_busy && !ir_busy)
                    begin
                        sonar_rem_reg  <= sonar_quot[VAR_W-1:0];
                        ir_rem_reg     <= ir_quot[VAR_W-1:0];
                        sonar_root_reg <= '0;
                        ir_root_reg    <= '0;
                        bit_reg        <= VAR_W'(1) << (VAR_W - 2);
                        loop_reg       <= LOOP_W'(ROOT_W);
                        state_reg      <= ST_SQRT;
                    end
                end

                ST_SQRT:
                begin
                    // one root bit per cycle
                    if (sonar_rem_reg >= sonar_trial)
                    begin
                        sonar_rem_reg  <= sonar_rem_reg - sonar_trial;
                        sonar_root_reg <= (sonar_root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        sonar_root_reg <= sonar_root_reg >> 1;
                    end
                    if (ir_rem_reg >= ir_trial)
                    begin
                        ir_rem_reg  <= ir_rem_reg - ir_trial;
                        ir_root_reg <= (ir_root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        ir_root_reg <= ir_root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    loop_reg <= loop_reg - LOOP_W'(1);
                    if (loop_reg == LOOP_W'(1))
                    begin
                        state_reg <= ST_LIMIT;
                    end
                end

                ST_LIMIT:
                begin
                    sonar_low_reg <= (LIMIT_W'(sonar_avg_reg) > sonar_ks)
                                     ? LIMIT_W'(sonar_avg_reg) - sonar_ks : '0;
                    ir_high_reg   <= ir_high_sum[LIMIT_W] ? {LIMIT_W{1'b1}}
                                                          : ir_high_sum[LIMIT_W-1:0];
                    calibrated_reg <= 1'b1;
                    fill_reg       <= '0;
                    slot_reg       <= '0;
                    sonar_wtot_reg <= '0;
                    ir_wtot_reg    <= '0;
                    state_reg      <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        result_reg.action        <= action_reg;
                        result_reg.sonar_average <= sonar_avg_reg;
                        result_reg.ir_average    <= ir_avg_reg;
                        result_reg.hits_so_far   <= hit_reg;
                        result_valid_reg         <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
